// File: sv/dsa_pkg.sv
// Shared codes, widths and types of the descriptor slot allocator.
package dsa_pkg;

  localparam int IDX_W  = 12;
  localparam int CAP_W  = 13;
  localparam int INC_W  = 16;
  localparam int ADDR_W = 64;
  localparam int MODE_W = 3;
  localparam int STAT_W = 3;
  localparam int REG_W  = 3;
  localparam int KIND_W = 2;

  // Operation codes on in_mode.
  localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FREE    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RESERVE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LOOKUP  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;

  // Status codes on out_status.
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_EXHAUSTED = 3'd1;
  localparam logic [STAT_W-1:0] ST_RANGE     = 3'd2;
  localparam logic [STAT_W-1:0] ST_COUNT     = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

  // Configuration register indexes.
  localparam logic [REG_W-1:0] REG_CAPACITY  = 3'd0;
  localparam logic [REG_W-1:0] REG_INCREMENT = 3'd1;
  localparam logic [REG_W-1:0] REG_CPU_BASE  = 3'd2;
  localparam logic [REG_W-1:0] REG_GPU_BASE  = 3'd3;
  localparam logic [REG_W-1:0] REG_HEAP_KIND = 3'd4;
  localparam logic [REG_W-1:0] REG_SHADER    = 3'd5;

  localparam logic [KIND_W-1:0] HEAP_SHADER_RES = 2'd2;

  // Per-item control handed from the decision stage to the address unit.
  typedef struct packed {
    logic              valid;
    logic              emit;
    logic              from_queue;
    logic [STAT_W-1:0] status;
  } dsa_ctl_t;

  // Address-forming configuration.
  typedef struct packed {
    logic [INC_W-1:0]  inc;
    logic [ADDR_W-1:0] cpu_base;
    logic [ADDR_W-1:0] gpu_base;
    logic              gpu_en;
  } dsa_cfg_t;

endpackage

// File: sv/descriptor_slot_allocator.sv
// Top level of the descriptor slot allocator: free queue, slot counter, config.
//
// Usage:
//   Command channel: drive in_mode, in_slot_index and in_reserve_count with
//   start high; the item is taken at a rising edge where start is high and
//   busy is low. busy stays low, so an item can be taken every cycle.
//   Result channel: out_valid is high for one cycle per item with
//   out_slot_out, out_cpu_address, out_gpu_address and out_status. Results
//   come in item order; each passes the decision registers, the product
//   stage and the output registers. The receiver cannot stall.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_wdata;
//   cfg_ready is always high. Write only while no item is in flight.
// Throughput: one item per cycle. The queue, counter and status are settled
// at the accepting edge while the free-queue memory is read at the current
// head; the stride multiply gets one stage and the 64-bit base adds another.
// Reset: synchronous, active low. The queue is empty and the slot counter
// zero after reset; the queue memory needs no clearing pass since an entry
// is only read after it was written.
module descriptor_slot_allocator #(
  parameter int MAX_SLOTS = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [dsa_pkg::MODE_W-1:0]    in_mode,
  input  logic [dsa_pkg::IDX_W-1:0]     in_slot_index,
  input  logic [dsa_pkg::CAP_W-1:0]     in_reserve_count,
  // result channel
  output logic                          out_valid,
  output logic [dsa_pkg::IDX_W-1:0]     out_slot_out,
  output logic [dsa_pkg::ADDR_W-1:0]    out_cpu_address,
  output logic [dsa_pkg::ADDR_W-1:0]    out_gpu_address,
  output logic [dsa_pkg::STAT_W-1:0]    out_status,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dsa_pkg::REG_W-1:0]     cfg_index,
  input  logic [dsa_pkg::ADDR_W-1:0]    cfg_wdata
);
  import dsa_pkg::*;

  // Queue count reaches MAX_SLOTS; slot values reach the effective capacity.
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int EW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int PTR_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(MAX_SLOTS - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // Configuration registers.
  logic [CAP_W-1:0]  capacity_r;
  logic [INC_W-1:0]  increment_r;
  logic [ADDR_W-1:0] cpu_base_r;
  logic [ADDR_W-1:0] gpu_base_r;
  logic [KIND_W-1:0] heap_kind_r;
  logic              shader_vis_r;

  // Allocator state.
  logic [PTR_W-1:0] queue_head_r, queue_head_nxt;
  logic [PTR_W-1:0] queue_tail_r, queue_tail_nxt;
  logic [CNT_W-1:0] queue_count_r, queue_count_nxt;
  logic [EW-1:0]    next_slot_r, next_slot_nxt;

  logic [IDX_W-1:0] free_queue [MAX_SLOTS];
  logic [IDX_W-1:0] queue_rd_r;
  logic             queue_we;

  dsa_ctl_t      ctl_r, ctl_nxt;
  logic [EW-1:0] slot_r, slot_nxt;
  dsa_cfg_t      addr_cfg;

  logic          accept;
  logic [EW-1:0] cap_eff;
  logic [EW-1:0] idx_ext;
  logic [EW-1:0] cnt_ext;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Clamp the programmed capacity to the built table size.
  assign cap_eff = (EW'(capacity_r) > EW'(MAX_SLOTS)) ? EW'(MAX_SLOTS) : EW'(capacity_r);
  assign idx_ext = EW'(in_slot_index);
  assign cnt_ext = EW'(in_reserve_count);

  // Config writes; a write beyond the register list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r   <= '0;
      increment_r  <= '0;
      cpu_base_r   <= '0;
      gpu_base_r   <= '0;
      heap_kind_r  <= HEAP_SHADER_RES;
      shader_vis_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CAPACITY:  capacity_r   <= cfg_wdata[CAP_W-1:0];
        REG_INCREMENT: increment_r  <= cfg_wdata[INC_W-1:0];
        REG_CPU_BASE:  cpu_base_r   <= cfg_wdata;
        REG_GPU_BASE:  gpu_base_r   <= cfg_wdata;
        REG_HEAP_KIND: heap_kind_r  <= cfg_wdata[KIND_W-1:0];
        REG_SHADER:    shader_vis_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Decide the item at its accepting edge. Errors leave the state alone.
  always_comb begin
    queue_head_nxt  = queue_head_r;
    queue_tail_nxt  = queue_tail_r;
    queue_count_nxt = queue_count_r;
    next_slot_nxt   = next_slot_r;
    queue_we        = 1'b0;
    ctl_nxt         = '0;
    slot_nxt        = '0;
    if (accept) begin
      ctl_nxt.valid  = 1'b1;
      ctl_nxt.status = ST_OK;
      unique case (in_mode)
        MODE_ALLOC: begin
          // Prefer the oldest freed slot; fall back to the bump counter.
          if (queue_count_r != '0) begin
            ctl_nxt.emit       = 1'b1;
            ctl_nxt.from_queue = 1'b1;
            queue_head_nxt     = wrap_inc(queue_head_r);
            queue_count_nxt    = queue_count_r - 1'b1;
          end else if (next_slot_r < cap_eff) begin
            ctl_nxt.emit  = 1'b1;
            slot_nxt      = next_slot_r;
            next_slot_nxt = next_slot_r + 1'b1;
          end else begin
            ctl_nxt.status = ST_EXHAUSTED;
          end
        end
        MODE_FREE: begin
          if (idx_ext >= cap_eff) begin
            ctl_nxt.status = ST_RANGE;
          end else if (queue_count_r == CNT_W'(MAX_SLOTS)) begin
            ctl_nxt.status = ST_FULL;
          end else begin
            queue_we        = 1'b1;
            queue_tail_nxt  = wrap_inc(queue_tail_r);
            queue_count_nxt = queue_count_r + 1'b1;
          end
        end
        MODE_RESERVE: begin
          if (cnt_ext > cap_eff) begin
            ctl_nxt.status = ST_COUNT;
          end else if (next_slot_r < cnt_ext) begin
            next_slot_nxt = cnt_ext;
          end
        end
        MODE_LOOKUP: begin
          if (idx_ext >= cap_eff) begin
            ctl_nxt.status = ST_RANGE;
          end else begin
            ctl_nxt.emit = 1'b1;
            slot_nxt     = idx_ext;
          end
        end
        MODE_CLEAR: begin
          queue_head_nxt  = '0;
          queue_tail_nxt  = '0;
          queue_count_nxt = '0;
          next_slot_nxt   = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_head_r  <= '0;
      queue_tail_r  <= '0;
      queue_count_r <= '0;
      next_slot_r   <= '0;
      ctl_r         <= '0;
    end else begin
      queue_head_r  <= queue_head_nxt;
      queue_tail_r  <= queue_tail_nxt;
      queue_count_r <= queue_count_nxt;
      next_slot_r   <= next_slot_nxt;
      ctl_r         <= ctl_nxt;
    end
    slot_r <= slot_nxt;
  end

  // Free-queue memory: write at the tail, registered read at the head.
  always_ff @(posedge clk) begin
    if (queue_we) begin
      free_queue[queue_tail_r] <= in_slot_index;
    end
    queue_rd_r <= free_queue[queue_head_r];
  end

  assign addr_cfg.inc      = increment_r;
  assign addr_cfg.cpu_base = cpu_base_r;
  assign addr_cfg.gpu_base = gpu_base_r;
  assign addr_cfg.gpu_en   = shader_vis_r && (heap_kind_r == HEAP_SHADER_RES);

  dsa_addr_gen #(
    .SLOT_W (EW)
  ) u_addr (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl_r),
    .slot            (slot_r),
    .queue_data      (queue_rd_r),
    .cfg             (addr_cfg),
    .out_valid       (out_valid),
    .out_slot_out    (out_slot_out),
    .out_cpu_address (out_cpu_address),
    .out_gpu_address (out_gpu_address),
    .out_status      (out_status)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    queue_count_r <= CNT_W'(MAX_SLOTS))
    else $error("free queue count above table size");

  a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
    (queue_count_r == '0 || queue_count_r == CNT_W'(MAX_SLOTS)) |->
      queue_head_r == queue_tail_r)
    else $error("queue pointers disagree with empty or full count");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == MODE_CLEAR) |=> (queue_count_r == '0 && next_slot_r == '0))
    else $error("clear left allocator state behind");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##3 out_valid)
    else $error("result missing three cycles after accept");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_slot_out == '0 && out_cpu_address == '0 && out_gpu_address == '0))
    else $error("error result carries a nonzero payload");
`endif

endmodule

// File: sv/dsa_addr_gen.sv
// Address unit: picks the slot, multiplies by the stride, adds the bases.
module dsa_addr_gen #(
  parameter int SLOT_W = 13
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dsa_pkg::dsa_ctl_t             ctl,
  input  logic [SLOT_W-1:0]             slot,
  input  logic [dsa_pkg::IDX_W-1:0]     queue_data,
  input  dsa_pkg::dsa_cfg_t             cfg,
  output logic                          out_valid,
  output logic [dsa_pkg::IDX_W-1:0]     out_slot_out,
  output logic [dsa_pkg::ADDR_W-1:0]    out_cpu_address,
  output logic [dsa_pkg::ADDR_W-1:0]    out_gpu_address,
  output logic [dsa_pkg::STAT_W-1:0]    out_status
);
  import dsa_pkg::*;

  localparam int PROD_W = SLOT_W + INC_W;

  logic [SLOT_W-1:0] slot_sel;
  logic [PROD_W-1:0] prod_nxt;

  logic              p_valid_r;
  logic              p_emit_r;
  logic [STAT_W-1:0] p_status_r;
  logic [SLOT_W-1:0] p_slot_r;
  logic [PROD_W-1:0] p_prod_r;

  logic              valid_r;
  logic [IDX_W-1:0]  slot_r;
  logic [ADDR_W-1:0] cpu_r;
  logic [ADDR_W-1:0] gpu_r;
  logic [STAT_W-1:0] status_r;

  assign slot_sel = ctl.from_queue ? SLOT_W'(queue_data) : slot;
  assign prod_nxt = PROD_W'(slot_sel) * PROD_W'(cfg.inc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      p_valid_r <= ctl.valid;
      valid_r   <= p_valid_r;
    end
    p_emit_r   <= ctl.emit;
    p_status_r <= ctl.status;
    p_slot_r   <= slot_sel;
    p_prod_r   <= prod_nxt;
    status_r   <= p_status_r;
    if (p_emit_r) begin
      slot_r <= p_slot_r[IDX_W-1:0];
      cpu_r  <= cfg.cpu_base + ADDR_W'(p_prod_r);
      gpu_r  <= cfg.gpu_en ? cfg.gpu_base + ADDR_W'(p_prod_r) : '0;
    end else begin
      slot_r <= '0;
      cpu_r  <= '0;
      gpu_r  <= '0;
    end
  end

  assign out_valid       = valid_r;
  assign out_slot_out    = slot_r;
  assign out_cpu_address = cpu_r;
  assign out_gpu_address = gpu_r;
  assign out_status      = status_r;

endmodule

// File: test/descriptor_slot_allocator_tb.sv
// Self-checking testbench for the descriptor slot allocator: free queue, slot counter, addresses.
module descriptor_slot_allocator_tb;
  import dsa_pkg::*;

  localparam int MAX_SLOTS   = 4096;
  localparam int IDX_MAX     = MAX_SLOTS - 1;
  localparam int CNT_MAX     = (1 << CAP_W) - 1;
  localparam int INC_MAX     = (1 << INC_W) - 1;
  localparam int KIND_MAX    = (1 << KIND_W) - 1;
  localparam int MODE_MAX    = (1 << MODE_W) - 1;
  localparam int IDLE_PCT    = 21;
  localparam int CALM_FROM   = 600;    // no sender idling for items in this range
  localparam int CALM_TO     = 850;
  localparam int QUIET_LIMIT = 2000;   // cycles with no handshake and no result before giving up
  localparam int TAIL_CYCLES = 8;      // lets the last result out of the pipeline
  localparam int SHOW_LIMIT  = 10;
  localparam int PHASES      = 8;
  localparam int PHASE_OPS   = 165;

  // Codes beyond the defined ones: spare register slot and first no-op mode.
  localparam logic [REG_W-1:0]  REG_SPARE  = REG_SHADER + 3'd1;
  localparam logic [MODE_W-1:0] MODE_SPARE = MODE_CLEAR + 3'd1;

  typedef enum logic [1:0] {ACT_OP, ACT_CFG, ACT_DRAIN} act_t;

  // One step of the stimulus plan: a command item, a register write or a drain pause.
  typedef struct packed {
    act_t              act;
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  idx;
    logic [CAP_W-1:0]  cnt;
    logic [REG_W-1:0]  reg_idx;
    logic [ADDR_W-1:0] data;
  } plan_t;

  typedef struct packed {
    logic [IDX_W-1:0]  slot;
    logic [ADDR_W-1:0] cpu;
    logic [ADDR_W-1:0] gpu;
    logic [STAT_W-1:0] status;
  } slot_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [MODE_W-1:0] in_mode = '0;
  logic [IDX_W-1:0]  in_slot_index = '0;
  logic [CAP_W-1:0]  in_reserve_count = '0;
  logic              out_valid;
  logic [IDX_W-1:0]  out_slot_out;
  logic [ADDR_W-1:0] out_cpu_address;
  logic [ADDR_W-1:0] out_gpu_address;
  logic [STAT_W-1:0] out_status;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [REG_W-1:0]  cfg_index = '0;
  logic [ADDR_W-1:0] cfg_wdata = '0;

  descriptor_slot_allocator #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_slot_index    (in_slot_index),
    .in_reserve_count (in_reserve_count),
    .out_valid        (out_valid),
    .out_slot_out     (out_slot_out),
    .out_cpu_address  (out_cpu_address),
    .out_gpu_address  (out_gpu_address),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Allocator state as the block should hold it, updated at each accepted edge.
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0]  fq_mem [MAX_SLOTS];
  int                fq_head = 0;
  int                fq_tail = 0;
  int                fq_count = 0;
  int                next_fresh = 0;      // first slot never handed out by the counter
  logic [CAP_W-1:0]  set_capacity = '0;
  logic [INC_W-1:0]  set_stride = '0;
  logic [ADDR_W-1:0] set_cpu_base = '0;
  logic [ADDR_W-1:0] set_gpu_base = '0;
  logic [KIND_W-1:0] set_heap_kind = HEAP_SHADER_RES;
  logic              set_shader = 1'b0;

  slot_result_t      awaited_results [$];
  plan_t             plan [$];
  plan_t             cur = '0;
  bit                holding = 1'b0;     // cur is on the pins and not yet taken
  bit                cmd_taken = 1'b0;
  bit                cfg_taken = 1'b0;
  int                ops_sent = 0;
  int                quiet_cycles = 0;
  int                fail_count = 0;

  // Addresses of a slot: both wrap modulo 2^64, GPU only for visible shader heaps.
  function automatic slot_result_t place_slot(input int slot);
    slot_result_t      r;
    logic [ADDR_W-1:0] off;
    off = ADDR_W'(slot) * ADDR_W'(set_stride);
    r.slot = IDX_W'(slot);
    r.cpu = set_cpu_base + off;
    r.gpu = (set_shader && set_heap_kind == HEAP_SHADER_RES) ? set_gpu_base + off : '0;
    r.status = ST_OK;
    return r;
  endfunction

  // Apply one command to the allocator state and return the result it must produce.
  // Errors leave the state alone and zero every field but status.
  function automatic slot_result_t run_slot_op(input logic [MODE_W-1:0] mode,
                                               input logic [IDX_W-1:0] idx,
                                               input logic [CAP_W-1:0] cnt);
    slot_result_t r;
    int           cap;
    int           slot;
    r = '0;
    cap = (int'(set_capacity) < MAX_SLOTS) ? int'(set_capacity) : MAX_SLOTS;
    case (mode)
      MODE_ALLOC: begin
        // Recycled slots first, in free order, even above a reduced capacity.
        if (fq_count > 0) begin
          slot = int'(fq_mem[fq_head]);
          fq_head = (fq_head + 1) % MAX_SLOTS;
          fq_count--;
          r = place_slot(slot);
        end else if (next_fresh < cap) begin
          r = place_slot(next_fresh);
          next_fresh++;
        end else begin
          r.status = ST_EXHAUSTED;
        end
      end
      MODE_FREE: begin
        if (int'(idx) >= cap) begin
          r.status = ST_RANGE;
        end else if (fq_count >= MAX_SLOTS) begin
          r.status = ST_FULL;
        end else begin
          fq_mem[fq_tail] = idx;
          fq_tail = (fq_tail + 1) % MAX_SLOTS;
          fq_count++;
        end
      end
      MODE_RESERVE: begin
        // The counter only moves up.
        if (int'(cnt) > cap) begin
          r.status = ST_COUNT;
        end else if (next_fresh < int'(cnt)) begin
          next_fresh = int'(cnt);
        end
      end
      MODE_LOOKUP: begin
        if (int'(idx) >= cap) begin
          r.status = ST_RANGE;
        end else begin
          r = place_slot(int'(idx));
        end
      end
      MODE_CLEAR: begin
        fq_head = 0;
        fq_tail = 0;
        fq_count = 0;
        next_fresh = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Registers keep only their own width; the spare indexes hold nothing.
  task automatic write_setting(input logic [REG_W-1:0] reg_idx, input logic [ADDR_W-1:0] data);
    case (reg_idx)
      REG_CAPACITY:  set_capacity = data[CAP_W-1:0];
      REG_INCREMENT: set_stride = data[INC_W-1:0];
      REG_CPU_BASE:  set_cpu_base = data;
      REG_GPU_BASE:  set_gpu_base = data;
      REG_HEAP_KIND: set_heap_kind = data[KIND_W-1:0];
      REG_SHADER:    set_shader = data[0];
      default: ;
    endcase
  endtask

  task automatic flag_result(input string what, input slot_result_t want,
                             input slot_result_t seen);
    fail_count++;
    if (fail_count <= SHOW_LIMIT)
      $display("%s: slot %0d/%0d cpu %h/%h gpu %h/%h status %0d/%0d (expected/actual)",
               what, want.slot, seen.slot, want.cpu, seen.cpu, want.gpu, seen.gpu,
               want.status, seen.status);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: check the result of this edge first, then take in what the edge
  // accepted, so ordering inside the time step never matters.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    slot_result_t seen;
    slot_result_t want;
    bit           op_hs;
    bit           cfg_hs;
    if (!rst_n) begin
      cmd_taken <= 1'b0;
      cfg_taken <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      op_hs = start && busy === 1'b0;
      cfg_hs = cfg_valid && cfg_ready === 1'b1;
      // Treat an unknown strobe as a result so it cannot slip by.
      if (out_valid !== 1'b0) begin
        seen = {out_slot_out, out_cpu_address, out_gpu_address, out_status};
        if (awaited_results.size() == 0) begin
          flag_result("unexpected result", '0, seen);
        end else begin
          want = awaited_results.pop_front();
          if (seen !== want)
            flag_result("result mismatch", want, seen);
        end
      end
      if (op_hs)
        awaited_results.push_back(run_slot_op(in_mode, in_slot_index, in_reserve_count));
      if (cfg_hs)
        write_setting(cfg_index, cfg_wdata);
      cmd_taken <= op_hs;
      cfg_taken <= cfg_hs;
      quiet_cycles <= (op_hs || cfg_hs || out_valid !== 1'b0) ? 0 : quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: walk the plan at falling edges. Items idle at random; register
  // writes and drain pauses hold until no result is outstanding.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : driver
    bit go_op;
    bit go_cfg;
    go_op = 1'b0;
    go_cfg = 1'b0;
    if (rst_n) begin
      if (cmd_taken || cfg_taken)
        holding = 1'b0;
      if (!holding && plan.size() != 0) begin
        case (plan[0].act)
          ACT_OP: begin
            if ((ops_sent >= CALM_FROM && ops_sent < CALM_TO) ||
                $urandom_range(99) >= IDLE_PCT) begin
              cur = plan.pop_front();
              holding = 1'b1;
              ops_sent++;
            end
          end
          ACT_CFG: begin
            if (awaited_results.size() == 0) begin
              cur = plan.pop_front();
              holding = 1'b1;
            end
          end
          default: begin
            if (awaited_results.size() == 0)
              void'(plan.pop_front());
          end
        endcase
      end
      go_op = holding && cur.act == ACT_OP;
      go_cfg = holding && cur.act == ACT_CFG;
    end
    start <= go_op;
    cfg_valid <= go_cfg;
    in_mode <= cur.mode;
    in_slot_index <= cur.idx;
    in_reserve_count <= cur.cnt;
    cfg_index <= cur.reg_idx;
    cfg_wdata <= cur.data;
  end

  // ---------------------------------------------------------------------------
  // Plan builders.
  // ---------------------------------------------------------------------------
  function automatic logic [ADDR_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Fill the bits above a narrow register with noise; the block must drop them.
  function automatic logic [ADDR_W-1:0] pad(input logic [ADDR_W-1:0] v, input int w);
    return (rand_word() << w) | v;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_base();
    int r;
    r = $urandom_range(3);
    if (r == 0)
      return '0;
    else if (r == 1)
      return '1;
    else
      return rand_word();
  endfunction

  // Mostly a slot below the effective capacity, sometimes anything.
  function automatic int pick_slot(input int ce);
    if (ce > 0 && $urandom_range(9) != 0)
      return $urandom_range(ce - 1);
    else
      return $urandom_range(IDX_MAX);
  endfunction

  task automatic plan_op(input logic [MODE_W-1:0] mode, input int idx, input int cnt);
    plan_t p;
    p = '0;
    p.act = ACT_OP;
    p.mode = mode;
    p.idx = IDX_W'(idx);
    p.cnt = CAP_W'(cnt);
    plan.push_back(p);
  endtask

  task automatic plan_cfg(input logic [REG_W-1:0] reg_idx, input logic [ADDR_W-1:0] data);
    plan_t p;
    p = '0;
    p.act = ACT_CFG;
    p.reg_idx = reg_idx;
    p.data = data;
    plan.push_back(p);
  endtask

  task automatic plan_drain();
    plan_t p;
    p = '0;
    p.act = ACT_DRAIN;
    plan.push_back(p);
  endtask

  task automatic plan_setup(input int cap, input int stride, input logic [ADDR_W-1:0] cpu,
                            input logic [ADDR_W-1:0] gpu, input int kind, input int shader);
    plan_cfg(REG_CAPACITY, pad(ADDR_W'(cap), CAP_W));
    plan_cfg(REG_INCREMENT, pad(ADDR_W'(stride), INC_W));
    plan_cfg(REG_CPU_BASE, cpu);
    plan_cfg(REG_GPU_BASE, gpu);
    plan_cfg(REG_HEAP_KIND, pad(ADDR_W'(kind), KIND_W));
    plan_cfg(REG_SHADER, pad(ADDR_W'(shader), 1));
  endtask

  // Mix weighted toward alloc/free traffic so the queue and counter keep moving.
  task automatic plan_random_op(input int ce);
    int r;
    r = $urandom_range(99);
    if (r < 34)
      plan_op(MODE_ALLOC, $urandom_range(IDX_MAX), $urandom_range(CNT_MAX));
    else if (r < 62)
      plan_op(MODE_FREE, pick_slot(ce), $urandom_range(CNT_MAX));
    else if (r < 72)
      plan_op(MODE_LOOKUP, pick_slot(ce), $urandom_range(CNT_MAX));
    else if (r < 84)
      plan_op(MODE_RESERVE, $urandom_range(IDX_MAX),
              ($urandom_range(99) < 85) ? $urandom_range(ce) : $urandom_range(CNT_MAX));
    else if (r < 88)
      plan_op(MODE_CLEAR, $urandom_range(IDX_MAX), $urandom_range(CNT_MAX));
    else if (r < 92)
      plan_op(MODE_W'($urandom_range(MODE_MAX, MODE_SPARE)), $urandom_range(IDX_MAX),
              $urandom_range(CNT_MAX));
    else
      plan_op(MODE_W'($urandom_range(MODE_MAX)), $urandom_range(IDX_MAX),
              $urandom_range(CNT_MAX));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int r;
    int cap;
    bit timed_out;
    timed_out = 1'b0;

    // Reset settings give zero capacity: everything but reserve zero and the no-op modes fails.
    plan_op(MODE_ALLOC, 0, 0);
    plan_op(MODE_FREE, 0, 0);
    plan_op(MODE_LOOKUP, IDX_MAX, 0);
    plan_op(MODE_RESERVE, 0, 0);
    plan_op(MODE_RESERVE, IDX_MAX, 1);
    for (int m = MODE_SPARE; m <= MODE_MAX; m++)
      plan_op(MODE_W'(m), $urandom_range(IDX_MAX), $urandom_range(CNT_MAX));

    // Full table, widest stride, bases at all ones so the adds wrap.
    plan_setup(MAX_SLOTS, INC_MAX, '1, '1, HEAP_SHADER_RES, 1);
    plan_op(MODE_ALLOC, IDX_MAX, CNT_MAX);
    plan_op(MODE_ALLOC, 0, 0);
    plan_op(MODE_LOOKUP, IDX_MAX, CNT_MAX);
    plan_op(MODE_FREE, IDX_MAX, 0);
    plan_op(MODE_FREE, IDX_MAX, 0);          // same slot queued twice
    plan_op(MODE_ALLOC, 0, 0);
    plan_op(MODE_ALLOC, 0, 0);
    plan_op(MODE_RESERVE, 0, MAX_SLOTS);
    plan_op(MODE_ALLOC, 0, 0);               // counter at the end, queue empty
    plan_op(MODE_RESERVE, 0, CNT_MAX);
    plan_op(MODE_RESERVE, 0, 10);            // below the counter: no change
    plan_op(MODE_CLEAR, IDX_MAX, CNT_MAX);
    plan_op(MODE_ALLOC, 0, 0);

    // Shrink capacity under a queued slot: it still comes out, lookups refuse it.
    plan_op(MODE_FREE, 100, 0);
    plan_cfg(REG_CAPACITY, pad(ADDR_W'(50), CAP_W));
    plan_op(MODE_ALLOC, 0, 0);
    plan_op(MODE_LOOKUP, 100, 0);
    plan_cfg(REG_CAPACITY, pad(ADDR_W'(CNT_MAX), CAP_W));   // clamps to the table size
    plan_op(MODE_LOOKUP, IDX_MAX, 0);

    // GPU address only for the shader heap with visibility on.
    plan_cfg(REG_HEAP_KIND, pad(ADDR_W'(KIND_MAX), KIND_W));
    plan_op(MODE_LOOKUP, 7, 0);
    plan_cfg(REG_HEAP_KIND, pad('0, KIND_W));
    plan_op(MODE_LOOKUP, 7, 0);
    plan_cfg(REG_HEAP_KIND, pad(ADDR_W'(HEAP_SHADER_RES), KIND_W));
    plan_cfg(REG_SHADER, pad('0, 1));
    plan_op(MODE_LOOKUP, 7, 0);
    plan_cfg(REG_SPARE, rand_word());
    plan_cfg(REG_SPARE + 3'd1, rand_word());
    plan_cfg(REG_SHADER, pad(ADDR_W'(1), 1));
    plan_op(MODE_LOOKUP, 7, 0);

    // Random phases, each under fresh settings; small tables dominate so the
    // counter runs out and queued slots outlive capacity changes.
    for (int p = 0; p < PHASES; p++) begin
      r = $urandom_range(99);
      if (r < 55)
        cap = $urandom_range(48, 1);
      else if (r < 70)
        cap = $urandom_range(MAX_SLOTS);
      else if (r < 80)
        cap = $urandom_range(CNT_MAX, MAX_SLOTS + 1);
      else if (r < 88)
        cap = MAX_SLOTS;
      else if (r < 92)
        cap = 0;
      else
        cap = $urandom_range(8);
      r = $urandom_range(3);
      plan_setup(cap,
                 (r == 0) ? 0 : (r == 1) ? INC_MAX : $urandom_range(INC_MAX),
                 pick_base(), pick_base(), $urandom_range(KIND_MAX), $urandom_range(1));
      for (int k = 0; k < PHASE_OPS; k++) begin
        if (k == PHASE_OPS / 2)
          plan_drain();
        plan_random_op((cap < MAX_SLOTS) ? cap : MAX_SLOTS);
      end
    end

    // Release reset on a falling edge; the driver sees it from the next falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (!timed_out && (plan.size() != 0 || holding || awaited_results.size() != 0)) begin
      @(posedge clk);
      if (quiet_cycles >= QUIET_LIMIT)
        timed_out = 1'b1;
    end
    if (!timed_out)
      repeat (TAIL_CYCLES) @(posedge clk);

    if (!timed_out && fail_count == 0 && awaited_results.size() == 0) begin
      $display("[descriptor_slot_allocator] OK");
    end else begin
      $display("[descriptor_slot_allocator] ERROR");
    end
    $finish;
  end

endmodule
